// ----- hdl/ecd_pkg.sv -----
`default_nettype none

package ecd_pkg;

	// Field widths of the bar, result and configuration beats
	localparam int PRICE_W    = 32;
	localparam int AVG_W      = 48;
	localparam int FRAC_W     = 16;
	localparam int GAIN_W     = 17;
	localparam int PERIOD_W   = 8;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	typedef logic [AVG_W-1:0]     avg_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic signed [1:0]    cross_t;

	// Register indexes on the configuration channel
	localparam cfg_idx_t REG_FAST_PERIOD = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SLOW_PERIOD = cfg_idx_t'(1);
	localparam cfg_idx_t REG_FAST_GAIN   = cfg_idx_t'(2);
	localparam cfg_idx_t REG_SLOW_GAIN   = cfg_idx_t'(3);

	// Register reset values
	localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 8'd9;
	localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 8'd21;
	localparam logic [GAIN_W-1:0]   FAST_GAIN_RST   = 17'd13107;
	localparam logic [GAIN_W-1:0]   SLOW_GAIN_RST   = 17'd5958;

	// Gain of one in Q1.16
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Crossing codes
	localparam cross_t CROSS_NONE = 2'sb00;
	localparam cross_t CROSS_UP   = 2'sb01;
	localparam cross_t CROSS_DOWN = 2'sb11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_DIV,
		ST_APPLY,
		ST_EMIT
	} ecd_state_t;

endpackage

`default_nettype wire

// ----- hdl/ecd_ifs.sv -----
`default_nettype none

// Bar channel: one closing price per beat
interface ecd_price_if import ecd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PRICE_W-1:0]   close_price;

	modport source (output valid, output close_price, input ready);
	modport sink   (input valid, input close_price, output ready);
endinterface

// Result channel: crossing code and both averages per beat
interface ecd_result_if import ecd_pkg::*; ();
	logic   valid;
	logic   ready;
	cross_t cross_signal;
	avg_t   fast_average;
	avg_t   slow_average;

	modport source (output valid, output cross_signal, output fast_average,
		output slow_average, input ready);
	modport sink   (input valid, input cross_signal, input fast_average,
		input slow_average, output ready);
endinterface

// Configuration write channel
interface ecd_cfg_if import ecd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ema_crossover_detector_top.sv -----
// One shared unit runs the fast then the slow average: a shift-add multiplier (one gain
// bit per cycle) and a restoring divider (one quotient bit per cycle). The next bar beat
// can be taken in the cycle after the result is loaded into the output register.
// Reset clears bar count, averages and seed sums and loads default periods and gains.
`default_nettype none

module ema_crossover_detector_top import ecd_pkg::*; #(
	parameter int MAX_PERIOD  = 128,
	parameter int PRICE_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ecd_price_if.sink   bar,
	ecd_result_if.source result,
	ecd_cfg_if.sink     cfg
);

	localparam int PW    = (PRICE_WIDTH < PRICE_W) ? PRICE_WIDTH : PRICE_W;
	localparam int PER_W = $clog2(MAX_PERIOD + 1);
	localparam int SUM_W = PW + PER_W;
	localparam int DVD_W = SUM_W + FRAC_W;
	localparam int CNT_W = $clog2(DVD_W);

	function automatic logic [PER_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
		logic [PER_W-1:0] r;
		if (p == '0) begin
			r = PER_W'(1);
		end else if (int'(p) > MAX_PERIOD) begin
			r = PER_W'(MAX_PERIOD);
		end else begin
			r = PER_W'(p);
		end
		return r;
	endfunction

	ecd_state_t state_q, state_d;

	logic [PERIOD_W-1:0] fast_period_q, slow_period_q;
	logic [GAIN_W-1:0]   fast_gain_q, slow_gain_q;
	logic [COUNT_W-1:0]  bar_count_q;
	avg_t                fast_ema_q, slow_ema_q;
	logic [SUM_W-1:0]    fast_sum_q, slow_sum_q;

	logic [PW-1:0]       price_q;
	logic                sel_q;
	logic                seed_q;
	logic                prev_le_q, prev_ge_q;
	avg_t                mag_q;
	logic                neg_q;
	avg_t                acc_q;
	logic [FRAC_W-1:0]   gain_sr_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [PER_W-1:0]    rem_q;
	avg_t                quo_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	cross_t              out_cross_q;
	avg_t                out_fast_q, out_slow_q;

	// Per-average selection and arithmetic
	logic [PER_W-1:0]    pf, ps, per_sel;
	logic [GAIN_W-1:0]   gain_sel;
	avg_t                ema_sel;
	logic [SUM_W-1:0]    sum_sel, sum_new;
	logic [COUNT_W:0]    n_plus, per_ext;
	logic                is_follow, is_seed, gain_full;
	avg_t                target, diff, ema_applied;
	logic                tgt_ge;
	logic [AVG_W:0]      mul_sum;
	logic [PER_W:0]      div_trial, div_rem;
	logic                div_ge;
	logic                f_gt_s, f_lt_s;
	cross_t              cross_d;
	logic                out_free;
	logic                bar_acc;
	ecd_state_t          avg_done_next;

	assign pf       = clamp_period(fast_period_q);
	assign ps       = clamp_period(slow_period_q);
	assign per_sel  = sel_q ? ps : pf;
	assign gain_sel = sel_q ? slow_gain_q : fast_gain_q;
	assign ema_sel  = sel_q ? slow_ema_q : fast_ema_q;
	assign sum_sel  = sel_q ? slow_sum_q : fast_sum_q;
	assign sum_new  = sum_sel + SUM_W'(price_q);

	assign n_plus    = {1'b0, bar_count_q} + (COUNT_W+1)'(1);
	assign per_ext   = (COUNT_W+1)'(per_sel);
	assign is_follow = n_plus < per_ext;
	assign is_seed   = n_plus == per_ext;
	assign gain_full = gain_sel >= GAIN_ONE;

	assign target = avg_t'({price_q, {FRAC_W{1'b0}}});
	assign tgt_ge = target >= ema_sel;
	assign diff   = tgt_ge ? (target - ema_sel) : (ema_sel - target);

	// One gain bit per cycle, shifting the partial product right
	assign mul_sum = {1'b0, acc_q} + (gain_sr_q[0] ? {1'b0, mag_q} : '0);

	// One quotient bit per cycle
	assign div_trial = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge    = div_trial >= {1'b0, per_sel};
	assign div_rem   = div_ge ? (div_trial - {1'b0, per_sel}) : div_trial;

	assign ema_applied = seed_q ? quo_q : (neg_q ? (ema_sel - acc_q) : (ema_sel + acc_q));

	// Crossing against the averages before this bar
	assign f_gt_s = fast_ema_q > slow_ema_q;
	assign f_lt_s = fast_ema_q < slow_ema_q;
	always_comb begin
		cross_d = CROSS_NONE;
		if (bar_count_q >= COUNT_W'(ps)) begin
			if (prev_le_q && f_gt_s) begin
				cross_d = CROSS_UP;
			end else if (prev_ge_q && f_lt_s) begin
				cross_d = CROSS_DOWN;
			end
		end
	end

	assign out_free  = !out_valid_q || result.ready;
	assign bar.ready = (state_q == ST_IDLE);
	assign bar_acc   = bar.valid && bar.ready;
	assign cfg.ready = 1'b1;

	assign result.valid        = out_valid_q;
	assign result.cross_signal = out_cross_q;
	assign result.fast_average = out_fast_q;
	assign result.slow_average = out_slow_q;

	assign avg_done_next = sel_q ? ST_EMIT : ST_START;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (bar.valid) state_d = ST_START;
			end
			ST_START: begin
				if (is_follow || (!is_seed && gain_full)) begin
					state_d = avg_done_next;
				end else if (is_seed) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL, ST_DIV: begin
				if (cnt_q == '0) state_d = ST_APPLY;
			end
			ST_APPLY: state_d = avg_done_next;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_period_q <= FAST_PERIOD_RST;
			slow_period_q <= SLOW_PERIOD_RST;
			fast_gain_q   <= FAST_GAIN_RST;
			slow_gain_q   <= SLOW_GAIN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FAST_PERIOD: fast_period_q <= cfg.data[PERIOD_W-1:0];
				REG_SLOW_PERIOD: slow_period_q <= cfg.data[PERIOD_W-1:0];
				REG_FAST_GAIN:   fast_gain_q   <= cfg.data;
				REG_SLOW_GAIN:   slow_gain_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Averages, seed sums, bar count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count_q <= '0;
			fast_ema_q  <= '0;
			slow_ema_q  <= '0;
			fast_sum_q  <= '0;
			slow_sum_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_START: begin
					if (is_follow || is_seed) begin
						if (sel_q) slow_sum_q <= sum_new;
						else       fast_sum_q <= sum_new;
					end
					if (is_follow || (!is_seed && gain_full)) begin
						if (sel_q) slow_ema_q <= target;
						else       fast_ema_q <= target;
					end
				end
				ST_APPLY: begin
					if (sel_q) slow_ema_q <= ema_applied;
					else       fast_ema_q <= ema_applied;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (bar_count_q != COUNT_MAX) bar_count_q <= bar_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the shared multiply/divide unit
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (bar_acc) begin
					price_q   <= bar.close_price[PW-1:0];
					sel_q     <= 1'b0;
					prev_le_q <= !f_gt_s;
					prev_ge_q <= !f_lt_s;
				end
			end
			ST_START: begin
				seed_q    <= is_seed;
				mag_q     <= diff;
				neg_q     <= !tgt_ge;
				acc_q     <= '0;
				gain_sr_q <= gain_sel[FRAC_W-1:0];
				dvd_q     <= {sum_new, {FRAC_W{1'b0}}};
				rem_q     <= '0;
				quo_q     <= '0;
				cnt_q     <= is_seed ? CNT_W'(DVD_W - 1) : CNT_W'(FRAC_W - 1);
				if (is_follow || (!is_seed && gain_full)) sel_q <= 1'b1;
			end
			ST_MUL: begin
				acc_q     <= mul_sum[AVG_W:1];
				gain_sr_q <= gain_sr_q >> 1;
				cnt_q     <= cnt_q - 1'b1;
			end
			ST_DIV: begin
				rem_q <= div_rem[PER_W-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[AVG_W-2:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_APPLY: sel_q <= 1'b1;
			ST_EMIT: begin
				if (out_free) begin
					out_cross_q <= cross_d;
					out_fast_q  <= fast_ema_q;
					out_slow_q  <= slow_ema_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A taken bar starts work on the fast average
	assert property (@(posedge clk) disable iff (!arst_n)
		bar_acc |=> (state_q == ST_START && !sel_q))
		else $error("bar beat did not start the fast average");

	// Partial product never exceeds the distance being scaled
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (acc_q <= mag_q))
		else $error("multiplier accumulator exceeds operand");

	// Divider remainder stays below the period
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < per_sel))
		else $error("divider remainder out of range");

	// Bar count never goes backward
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (bar_count_q >= $past(bar_count_q)))
		else $error("bar count decreased");

	// A reported crossing has averages that differ
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cross_q != CROSS_NONE) |-> (out_fast_q != out_slow_q))
		else $error("crossing reported with equal averages");
`endif

endmodule

`default_nettype wire
